FILE: sv/ppvb_pkg.sv
// Shared types and constants for the point pose transform and voxel binning block.
package ppvb_pkg;

    localparam int GRID_LENGTH = 21;
    localparam int GRID_WIDTH  = 21;
    localparam int GRID_HEIGHT = 10;
    localparam logic [2:0][6:0] GRID_DIM = {7'(GRID_HEIGHT), 7'(GRID_WIDTH), 7'(GRID_LENGTH)};
    localparam int GRID_MAX = (GRID_LENGTH > GRID_WIDTH)
                              ? ((GRID_LENGTH > GRID_HEIGHT) ? GRID_LENGTH : GRID_HEIGHT)
                              : ((GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT);
    localparam int CELL_W = $clog2(GRID_MAX);
    localparam int IDX_W  = 13;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 48;
    localparam int CFG_A_W = 3;

    localparam int XF_STAGES = 5;
    localparam int BN_STAGES = 3;

    localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh4000_0000;
    localparam logic [CFG_W-1:0] CUBE_OFFSETS_RESET = 48'd21475491850;

    typedef enum logic [CFG_A_W-1:0] {
        REG_ROT_W        = 3'd0,
        REG_ROT_X        = 3'd1,
        REG_ROT_Y        = 3'd2,
        REG_ROT_Z        = 3'd3,
        REG_SHIFT_X      = 3'd4,
        REG_SHIFT_Y      = 3'd5,
        REG_SHIFT_Z      = 3'd6,
        REG_CUBE_OFFSETS = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vec3_t;

    typedef struct packed {
        logic        [COORD_W-1:0] intensity;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic             in_grid;
        logic [IDX_W-1:0] cube_index;
        point_t           pt;
    } result_t;

endpackage

FILE: sv/ppvb_xform.sv
// Rotation by the configured quaternion and translation, as a five stage pipeline.
module ppvb_xform (
    input  logic            aclk,
    input  logic            aresetn,
    input  ppvb_pkg::quat_t quat,
    input  ppvb_pkg::vec3_t shift,
    input  logic            in_valid,
    output logic            in_ready,
    input  ppvb_pkg::point_t in_point,
    output logic            out_valid,
    input  logic            out_ready,
    output ppvb_pkg::point_t out_point
);
    import ppvb_pkg::*;

    localparam logic signed [65:0] ONE60  = 66'sd1 <<< 60;
    localparam logic signed [65:0] HALF30 = 66'sd1 <<< 29;

    function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
        return $signed({{2{v[63]}}, v});
    endfunction

    function automatic logic signed [31:0] to_q30(input logic signed [65:0] v);
        logic signed [65:0] t;
        logic signed [35:0] q;
        t = v + HALF30;
        q = $signed(t[65:30]);
        if (q > 36'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (q < -36'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return $signed(q[31:0]);
    endfunction

    logic [XF_STAGES-1:0] vld_reg;
    logic [XF_STAGES-1:0] vld_next;
    logic [XF_STAGES-1:0] adv;

    always_comb begin
        adv[XF_STAGES-1] = !vld_reg[XF_STAGES-1] || out_ready;
        for (int k = XF_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < XF_STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[XF_STAGES-1];

    // Stage 0: quaternion products.
    logic signed [63:0] s0_xx_reg, s0_yy_reg, s0_zz_reg;
    logic signed [63:0] s0_xy_reg, s0_xz_reg, s0_yz_reg;
    logic signed [63:0] s0_wx_reg, s0_wy_reg, s0_wz_reg;
    logic signed [31:0] s0_p_reg [3];
    logic [31:0]        s0_int_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s0_xx_reg  <= quat.x * quat.x;
            s0_yy_reg  <= quat.y * quat.y;
            s0_zz_reg  <= quat.z * quat.z;
            s0_xy_reg  <= quat.x * quat.y;
            s0_xz_reg  <= quat.x * quat.z;
            s0_yz_reg  <= quat.y * quat.z;
            s0_wx_reg  <= quat.w * quat.x;
            s0_wy_reg  <= quat.w * quat.y;
            s0_wz_reg  <= quat.w * quat.z;
            s0_p_reg[0] <= in_point.x;
            s0_p_reg[1] <= in_point.y;
            s0_p_reg[2] <= in_point.z;
            s0_int_reg <= in_point.intensity;
        end
    end

    // Stage 1: rotation matrix entries rounded to Q2.30.
    logic signed [31:0] s1_r_next [3][3];
    logic signed [31:0] s1_r_reg  [3][3];
    logic signed [31:0] s1_p_reg  [3];
    logic [31:0]        s1_int_reg;

    always_comb begin
        s1_r_next[0][0] = to_q30(ONE60 - ((sx66(s0_yy_reg) + sx66(s0_zz_reg)) <<< 1));
        s1_r_next[0][1] = to_q30((sx66(s0_xy_reg) - sx66(s0_wz_reg)) <<< 1);
        s1_r_next[0][2] = to_q30((sx66(s0_xz_reg) + sx66(s0_wy_reg)) <<< 1);
        s1_r_next[1][0] = to_q30((sx66(s0_xy_reg) + sx66(s0_wz_reg)) <<< 1);
        s1_r_next[1][1] = to_q30(ONE60 - ((sx66(s0_xx_reg) + sx66(s0_zz_reg)) <<< 1));
        s1_r_next[1][2] = to_q30((sx66(s0_yz_reg) - sx66(s0_wx_reg)) <<< 1);
        s1_r_next[2][0] = to_q30((sx66(s0_xz_reg) - sx66(s0_wy_reg)) <<< 1);
        s1_r_next[2][1] = to_q30((sx66(s0_yz_reg) + sx66(s0_wx_reg)) <<< 1);
        s1_r_next[2][2] = to_q30(ONE60 - ((sx66(s0_xx_reg) + sx66(s0_yy_reg)) <<< 1));
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_r_reg   <= s1_r_next;
            s1_p_reg   <= s0_p_reg;
            s1_int_reg <= s0_int_reg;
        end
    end

    // Stage 2: matrix times point, one product per entry.
    logic signed [63:0] s2_m_reg [3][3];
    logic [31:0]        s2_int_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 3; j++) begin
                    s2_m_reg[a][j] <= s1_r_reg[a][j] * s1_p_reg[j];
                end
            end
            s2_int_reg <= s1_int_reg;
        end
    end

    // Stage 3: row sums rounded half up to Q16.16.
    logic signed [65:0] s3_sum [3];
    logic signed [35:0] s3_rnd_next [3];
    logic signed [35:0] s3_rnd_reg  [3];
    logic [31:0]        s3_int_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s3_sum[a] = sx66(s2_m_reg[a][0]) + sx66(s2_m_reg[a][1])
                      + sx66(s2_m_reg[a][2]) + HALF30;
            s3_rnd_next[a] = $signed(s3_sum[a][65:30]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_rnd_reg <= s3_rnd_next;
            s3_int_reg <= s2_int_reg;
        end
    end

    // Stage 4: translation and saturation.
    logic signed [31:0] sh [3];
    logic signed [36:0] s4_sum [3];
    logic signed [31:0] s4_c_next [3];
    logic signed [31:0] s4_c_reg  [3];
    logic [31:0]        s4_int_reg;

    always_comb begin
        sh[0] = shift.x;
        sh[1] = shift.y;
        sh[2] = shift.z;
        for (int a = 0; a < 3; a++) begin
            s4_sum[a] = $signed({s3_rnd_reg[a][35], s3_rnd_reg[a]})
                      + $signed({{5{sh[a][31]}}, sh[a]});
            if (s4_sum[a] > 37'sd2147483647) begin
                s4_c_next[a] = 32'sh7fff_ffff;
            end else if (s4_sum[a] < -37'sd2147483648) begin
                s4_c_next[a] = 32'sh8000_0000;
            end else begin
                s4_c_next[a] = $signed(s4_sum[a][31:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_c_reg   <= s4_c_next;
            s4_int_reg <= s3_int_reg;
        end
    end

    assign out_point.x         = s4_c_reg[0];
    assign out_point.y         = s4_c_reg[1];
    assign out_point.z         = s4_c_reg[2];
    assign out_point.intensity = s4_int_reg;

endmodule

FILE: sv/ppvb_bin.sv
// Voxel binning with cube offsets and linear cube index, as a three stage pipeline.
module ppvb_bin (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ppvb_pkg::CFG_W-1:0]      cube_offs,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ppvb_pkg::point_t                in_point,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppvb_pkg::result_t               out_res
);
    import ppvb_pkg::*;

    localparam int BIN_HALF   = 25 * 65536;
    localparam int BIN_STEP   = 50;
    localparam int BIN_BIAS_Q = 700;
    localparam int BIN_BIAS   = BIN_BIAS_Q * BIN_STEP;
    localparam int BIN_RECIP  = 1311;
    localparam int CALC_W     = 20;

    logic [BN_STAGES-1:0] vld_reg;
    logic [BN_STAGES-1:0] vld_next;
    logic [BN_STAGES-1:0] adv;

    always_comb begin
        adv[BN_STAGES-1] = !vld_reg[BN_STAGES-1] || out_ready;
        for (int k = BN_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < BN_STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[BN_STAGES-1];

    // Stage 0: biased metre index and reciprocal estimate of the bin number.
    logic signed [31:0] c_in [3];
    logic signed [32:0] b0_sum [3];
    logic signed [16:0] b0_m [3];
    logic signed [17:0] b0_u18 [3];
    logic [27:0]        b0_prod [3];
    logic [16:0]        b0_u_next [3];
    logic [10:0]        b0_q_next [3];
    logic [16:0]        b0_u_reg [3];
    logic [10:0]        b0_q_reg [3];
    point_t             b0_pt_reg;

    always_comb begin
        c_in[0] = in_point.x;
        c_in[1] = in_point.y;
        c_in[2] = in_point.z;
        for (int a = 0; a < 3; a++) begin
            b0_sum[a]    = $signed({c_in[a][31], c_in[a]}) + 33'(BIN_HALF);
            b0_m[a]      = $signed(b0_sum[a][32:16]);
            b0_u18[a]    = $signed({b0_m[a][16], b0_m[a]}) + 18'(BIN_BIAS);
            b0_u_next[a] = b0_u18[a][16:0];
            b0_prod[a]   = 28'(b0_u_next[a]) * 28'(BIN_RECIP);
            b0_q_next[a] = b0_prod[a][26:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            b0_u_reg  <= b0_u_next;
            b0_q_reg  <= b0_q_next;
            b0_pt_reg <= in_point;
        end
    end

    // Stage 1: estimate correction, cube offset and grid check.
    logic [16:0]        b1_p50 [3];
    logic [10:0]        b1_q [3];
    logic signed [15:0] b1_off [3];
    logic signed [17:0] b1_cell [3];
    logic [CELL_W-1:0]  b1_cell_next [3];
    logic               b1_in_next;
    logic [CELL_W-1:0]  b1_cell_reg [3];
    logic               b1_in_reg;
    point_t             b1_pt_reg;

    always_comb begin
        b1_in_next = 1'b1;
        for (int a = 0; a < 3; a++) begin
            b1_p50[a]  = 17'(b0_q_reg[a]) * 17'(BIN_STEP);
            b1_q[a]    = (b1_p50[a] > b0_u_reg[a]) ? b0_q_reg[a] - 11'd1 : b0_q_reg[a];
            b1_off[a]  = $signed(cube_offs[16*a +: 16]);
            b1_cell[a] = $signed({7'b0, b1_q[a]}) - 18'(BIN_BIAS_Q)
                       + $signed({{2{b1_off[a][15]}}, b1_off[a]});
            if (b1_cell[a][17] || (b1_cell[a][16:0] >= 17'(GRID_DIM[a]))) begin
                b1_in_next = 1'b0;
            end
            b1_cell_next[a] = b1_cell[a][CELL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            b1_cell_reg <= b1_cell_next;
            b1_in_reg   <= b1_in_next;
            b1_pt_reg   <= b0_pt_reg;
        end
    end

    // Stage 2: linear cube index.
    logic [CALC_W-1:0] b2_idx;
    result_t           b2_res_next;
    result_t           b2_res_reg;

    always_comb begin
        b2_idx = CALC_W'(b1_cell_reg[0])
               + CALC_W'(b1_cell_reg[1]) * CALC_W'(GRID_LENGTH)
               + CALC_W'(b1_cell_reg[2]) * CALC_W'(GRID_LENGTH * GRID_WIDTH);
        b2_res_next.pt         = b1_pt_reg;
        b2_res_next.in_grid    = b1_in_reg;
        b2_res_next.cube_index = b1_in_reg ? b2_idx[IDX_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            b2_res_reg <= b2_res_next;
        end
    end

    assign out_res = b2_res_reg;

endmodule

FILE: sv/point_pose_transform_voxel_bin_top.sv
// Top level of the point pose transform and voxel binning block.
//
// Each request carries one lidar point in Q16.16 metres and an intensity word. The point is
// rotated by the configured quaternion (Q2.30, each part clamped to plus or minus one), moved
// by the configured translation and saturated to Q16.16; each map coordinate is then binned
// into 50 m cubes centered on multiples of 50 m, shifted by the signed per-axis cube offsets,
// and turned into a linear cube index with an in-grid flag. The block takes one point per
// cycle unless the output stalls, and passes it through eight register stages: quaternion
// products, matrix rounding, point products, row sums, translation, bin estimate, bin
// correction with grid check, and the linear index. Configuration writes take effect for
// points accepted after the write and must only be issued while no point is in flight.
module point_pose_transform_voxel_bin_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [ppvb_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [ppvb_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, point_z, point_intensity
    input  logic [127:0]                     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // map_x, map_y, map_z, map_intensity, cube_index, zero fill
    output logic [143:0]                     m_tdata,
    // in_grid
    output logic                             m_tuser
);
    import ppvb_pkg::*;

    function automatic logic signed [31:0] clamp_q(input logic [31:0] v);
        logic signed [31:0] s;
        s = $signed(v);
        if (s > Q_ONE) begin
            return Q_ONE;
        end else if (s < -Q_ONE) begin
            return -Q_ONE;
        end
        return s;
    endfunction

    quat_t            quat_reg;
    vec3_t            shift_reg;
    logic [CFG_W-1:0] offs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg  <= '{w: Q_ONE, x: '0, y: '0, z: '0};
            shift_reg <= '0;
            offs_reg  <= CUBE_OFFSETS_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ROT_W:        quat_reg.w  <= clamp_q(cfg_wdata[31:0]);
                REG_ROT_X:        quat_reg.x  <= clamp_q(cfg_wdata[31:0]);
                REG_ROT_Y:        quat_reg.y  <= clamp_q(cfg_wdata[31:0]);
                REG_ROT_Z:        quat_reg.z  <= clamp_q(cfg_wdata[31:0]);
                REG_SHIFT_X:      shift_reg.x <= $signed(cfg_wdata[31:0]);
                REG_SHIFT_Y:      shift_reg.y <= $signed(cfg_wdata[31:0]);
                REG_SHIFT_Z:      shift_reg.z <= $signed(cfg_wdata[31:0]);
                REG_CUBE_OFFSETS: offs_reg    <= cfg_wdata;
                default:          offs_reg    <= offs_reg;
            endcase
        end
    end

    point_t  in_point;
    point_t  xf_point;
    logic    xf_valid;
    logic    xf_ready;
    result_t res;

    assign in_point = s_tdata;

    ppvb_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quat      (quat_reg),
        .shift     (shift_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_point  (in_point),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_point (xf_point)
    );

    ppvb_bin u_bin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cube_offs (offs_reg),
        .in_valid  (xf_valid),
        .in_ready  (xf_ready),
        .in_point  (xf_point),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'b000, res.cube_index, res.pt};
    assign m_tuser = res.in_grid;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the point pose transform and voxel binning block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppvb_pkg::*;

    localparam longint UNIT     = 64'sd1073741824;
    localparam longint COS45    = 64'sd759250125;
    localparam longint METRE    = 64'sd65536;
    localparam longint BIN_HALF = 25 * METRE;
    localparam longint BIN_SPAN = 50 * METRE;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int PHASES = 12;
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] inten;
        bit          typed;
        logic [12:0] idx;
        bit          grid;
    } probe_t;

    // Rows marked typed run under the identity pose set at reset, so the map point
    // equals the input point and only the index and grid flag need to be given.
    probe_t probes [13] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd2425, 1'b1},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 13'd0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1, 13'd0, 1'b0},
        '{32'hFE0C_0000, 32'hFE0C_0000, 32'hFF06_0000, 32'hA5A5_A5A5, 1'b1, 13'd0, 1'b1},
        '{32'h01F4_0000, 32'h01F4_0000, 32'h00C8_0000, 32'h5A5A_5A5A, 1'b1, 13'd4409, 1'b1},
        '{32'hFDF2_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 13'd0, 1'b0},
        '{32'h0019_0000, 32'h0018_FFFF, 32'hFFE6_FFFF, 32'h8000_0000, 1'b1, 13'd1985, 1'b1},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 13'd0, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 13'd0, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC, 1'b0, 13'd0, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333, 1'b0, 13'd0, 1'b0},
        '{32'h0000_0000, 32'hFDF3_0000, 32'h00E1_0000, 32'h1234_5678, 1'b0, 13'd0, 1'b0},
        '{32'h0000_0000, 32'h020D_0000, 32'h00E0_FFFF, 32'h0000_0000, 1'b0, 13'd0, 1'b0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_A_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [127:0]         s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [143:0]         m_tdata;
    logic                 m_tuser;

    logic [CFG_W-1:0] pose_cfg [8];
    result_t          mapped_due [$];
    int               fail_count = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    bit               hold_req = 1'b0;
    bit               hold_seen = 1'b0;
    int               hold_left = 0;

    point_transform_voxel_bin_top_wrapper_guard guard_unused ();

    point_pose_transform_voxel_bin_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unit_clamp(logic [CFG_W-1:0] v);
        longint s;
        s = longint'($signed(v[31:0]));
        if (s > UNIT) return UNIT;
        if (s < -UNIT) return -UNIT;
        return s;
    endfunction

    function automatic longint round_q30(longint v);
        return sat_word((v + (UNIT >>> 1)) >>> 30);
    endfunction

    function automatic result_t map_point(point_t p);
        longint w, x, y, z;
        longint m [3][3];
        longint pt [3];
        longint cells [3];
        longint dims [3];
        logic [31:0] coord_out [3];
        longint coord, num, bin, shift;
        logic signed [95:0] acc, e, q;
        bit in_cube;
        result_t res;
        w = unit_clamp(pose_cfg[REG_ROT_W]);
        x = unit_clamp(pose_cfg[REG_ROT_X]);
        y = unit_clamp(pose_cfg[REG_ROT_Y]);
        z = unit_clamp(pose_cfg[REG_ROT_Z]);
        m[0][0] = round_q30((UNIT <<< 30) - 2 * (y * y + z * z));
        m[0][1] = round_q30(2 * (x * y - w * z));
        m[0][2] = round_q30(2 * (x * z + w * y));
        m[1][0] = round_q30(2 * (x * y + w * z));
        m[1][1] = round_q30((UNIT <<< 30) - 2 * (x * x + z * z));
        m[1][2] = round_q30(2 * (y * z - w * x));
        m[2][0] = round_q30(2 * (x * z - w * y));
        m[2][1] = round_q30(2 * (y * z + w * x));
        m[2][2] = round_q30((UNIT <<< 30) - 2 * (x * x + y * y));
        pt[0] = longint'(p.x);
        pt[1] = longint'(p.y);
        pt[2] = longint'(p.z);
        dims[0] = GRID_LENGTH;
        dims[1] = GRID_WIDTH;
        dims[2] = GRID_HEIGHT;
        in_cube = 1'b1;
        for (int a = 0; a < 3; a++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                e = m[a][j];
                q = pt[j];
                acc = acc + e * q;
            end
            acc = (acc + (96'sd1 <<< 29)) >>> 30;
            shift = longint'($signed(pose_cfg[int'(REG_SHIFT_X) + a][31:0]));
            coord = sat_word(longint'(acc) + shift);
            coord_out[a] = coord[31:0];
            num = coord + BIN_HALF;
            bin = num / BIN_SPAN;
            if (num % BIN_SPAN != 0 && num < 0) begin
                bin = bin - 1;
            end
            cells[a] = bin + longint'($signed(pose_cfg[REG_CUBE_OFFSETS][16*a +: 16]));
            if (cells[a] < 0 || cells[a] >= dims[a]) begin
                in_cube = 1'b0;
            end
        end
        res.pt.x = coord_out[0];
        res.pt.y = coord_out[1];
        res.pt.z = coord_out[2];
        res.pt.intensity = p.intensity;
        res.in_grid = in_cube;
        res.cube_index = in_cube
            ? IDX_W'(cells[0] + cells[1] * GRID_LENGTH + cells[2] * GRID_LENGTH * GRID_WIDTH)
            : '0;
        return res;
    endfunction

    function automatic logic [31:0] rand_coord(int kind);
        int k;
        case (kind)
            0: return 32'(longint'($urandom_range(0, 91750400)) - 64'sd45875200);
            1: return $urandom;
            2: begin
                k = int'($urandom_range(0, 40)) - 20;
                return 32'(k * 3276800 - 1638400 + int'($urandom_range(0, 4)) - 2);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic point_t rand_point();
        int r;
        int kind;
        point_t p;
        r = $urandom_range(0, 99);
        kind = (r < 65) ? 0 : (r < 80) ? 1 : (r < 93) ? 2 : 3;
        p.x = rand_coord(kind);
        p.y = rand_coord(kind);
        p.z = rand_coord(kind);
        p.intensity = $urandom;
        return p;
    endfunction

    function automatic logic [CFG_W-1:0] word48(longint v);
        return {16'h0000, v[31:0]};
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < 40) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic send_point(point_t p, bit typed, result_t want);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        mapped_due.insert(mapped_due.size(), typed ? want : map_point(p));
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
        cfg_wen <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        pose_cfg[r] = v;
    endtask

    task automatic apply_pose(int ph);
        logic [CFG_W-1:0] vals [8];
        logic [15:0] offs [3];
        vals[REG_ROT_W] = word48(UNIT);
        vals[REG_ROT_X] = '0;
        vals[REG_ROT_Y] = '0;
        vals[REG_ROT_Z] = '0;
        vals[REG_SHIFT_X] = '0;
        vals[REG_SHIFT_Y] = '0;
        vals[REG_SHIFT_Z] = '0;
        vals[REG_CUBE_OFFSETS] = CUBE_OFFSETS_RESET;
        case (ph)
            0: ;
            1: begin
                vals[REG_ROT_W] = word48(COS45);
                vals[REG_ROT_Z] = word48(COS45);
                vals[REG_SHIFT_X] = word48(100 * METRE);
                vals[REG_SHIFT_Y] = word48(-50 * METRE);
                vals[REG_SHIFT_Z] = word48(10 * METRE);
            end
            2: begin
                vals[REG_ROT_W] = word48(-UNIT);
                vals[REG_ROT_X] = word48(-UNIT);
                vals[REG_ROT_Y] = word48(-UNIT);
                vals[REG_ROT_Z] = word48(-UNIT);
                vals[REG_SHIFT_X] = 48'h0000_7FFF_FFFF;
                vals[REG_SHIFT_Y] = 48'h0000_8000_0000;
                vals[REG_CUBE_OFFSETS] = '0;
            end
            3: begin
                vals[REG_ROT_W] = 48'h0000_7FFF_FFFF;
                vals[REG_ROT_X] = 48'h0000_8000_0000;
                vals[REG_ROT_Y] = 48'h0000_4000_0001;
                vals[REG_ROT_Z] = 48'h0000_BFFF_FFFF;
                vals[REG_CUBE_OFFSETS] = 48'hFFFF_FFFF_FFFF;
            end
            4: begin
                vals[REG_ROT_W] = '0;
                vals[REG_ROT_X] = word48(UNIT);
                vals[REG_SHIFT_Z] = 48'h0000_8000_0000;
                vals[REG_CUBE_OFFSETS] = {16'h0000, 16'h8000, 16'h7FFF};
            end
            5: begin
                vals[REG_ROT_X] = word48(UNIT);
                vals[REG_ROT_Y] = word48(UNIT);
                vals[REG_ROT_Z] = word48(UNIT);
                vals[REG_SHIFT_X] = 48'h0000_FFFF_FFFF;
                vals[REG_SHIFT_Y] = 48'h0000_FFFF_FFFF;
                vals[REG_SHIFT_Z] = 48'h0000_FFFF_FFFF;
                vals[REG_CUBE_OFFSETS] = {16'd4, 16'd9, 16'd11};
            end
            default: begin
                for (int r = int'(REG_ROT_W); r <= int'(REG_ROT_Z); r++) begin
                    vals[r] = ($urandom_range(0, 9) < 6)
                        ? word48(longint'($urandom_range(0, 32'h8000_0000)) - UNIT)
                        : word48(longint'($urandom));
                end
                for (int r = int'(REG_SHIFT_X); r <= int'(REG_SHIFT_Z); r++) begin
                    vals[r] = ($urandom_range(0, 9) < 7)
                        ? word48(longint'($urandom_range(0, 52428800)) - 64'sd26214400)
                        : word48(longint'($urandom));
                end
                for (int a = 0; a < 3; a++) begin
                    offs[a] = ($urandom_range(0, 9) < 6)
                        ? 16'(int'($urandom_range(0, 34)) - 12)
                        : 16'($urandom);
                end
                vals[REG_CUBE_OFFSETS] = {offs[2], offs[1], offs[0]};
            end
        endcase
        for (int r = int'(REG_ROT_W); r <= int'(REG_CUBE_OFFSETS); r++) begin
            write_reg(cfg_reg_t'(r), vals[r]);
        end
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pt = m_tdata[127:0];
            got.cube_index = m_tdata[128 +: IDX_W];
            got.in_grid = m_tuser;
            if (mapped_due.size() == 0) begin
                report_mismatch("result with no point pending");
            end else begin
                want = mapped_due.pop_front();
                check_field("map_x", got.pt.x, want.pt.x);
                check_field("map_y", got.pt.y, want.pt.y);
                check_field("map_z", got.pt.z, want.pt.z);
                check_field("map_intensity", got.pt.intensity, want.pt.intensity);
                check_field("cube_index", 32'(got.cube_index), 32'(want.cube_index));
                check_field("in_grid", 32'(got.in_grid), 32'(want.in_grid));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        point_t p;
        result_t want;
        pose_cfg[REG_ROT_W] = word48(UNIT);
        pose_cfg[REG_ROT_X] = '0;
        pose_cfg[REG_ROT_Y] = '0;
        pose_cfg[REG_ROT_Z] = '0;
        pose_cfg[REG_SHIFT_X] = '0;
        pose_cfg[REG_SHIFT_Y] = '0;
        pose_cfg[REG_SHIFT_Z] = '0;
        pose_cfg[REG_CUBE_OFFSETS] = CUBE_OFFSETS_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) begin
            p.x = probes[i].x;
            p.y = probes[i].y;
            p.z = probes[i].z;
            p.intensity = probes[i].inten;
            want.pt = p;
            want.cube_index = probes[i].idx;
            want.in_grid = probes[i].grid;
            send_point(p, probes[i].typed, want);
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            while (mapped_due.size() != 0) @(posedge aclk);
            apply_pose(ph);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 74; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 74; end
                default: begin idle_pct = 18; stall_pct <= 18; end
            endcase
            if (ph == 0) begin
                hold_req <= ~hold_req;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_point(rand_point(), 1'b0, want);
            end
            s_tvalid <= 1'b0;
        end

        while (mapped_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

module point_transform_voxel_bin_top_wrapper_guard;
endmodule
